// ===== hw/rtl/stereo_pixel_composer_macros.svh =====
// ----------------------------------------------------------------------------
// stereo_pixel_composer assertion macros
// Clocked, reset-gated property helpers for the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef STEREO_PIXEL_COMPOSER_MACROS_SVH
`define STEREO_PIXEL_COMPOSER_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, register indexes and helpers of the stereo pixel composer.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef enum logic [2:0] {
    MODE_LEFT     = 3'd0,
    MODE_RIGHT    = 3'd1,
    MODE_SBS      = 3'd2,
    MODE_ANAGLYPH = 3'd3,
    MODE_ROW      = 3'd4,
    MODE_COLUMN   = 3'd5,
    MODE_BLEND    = 3'd6,
    MODE_LEFT_ALT = 3'd7
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned OCOL_W     = 13;
  localparam int unsigned OROW_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd5;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    mode_e              mode;
    logic               swap;
    logic [SIZE_W-1:0]  width_raw;
    logic [SIZE_W-1:0]  height_raw;
    logic               left_on;
    logic               right_on;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [OCOL_W-1:0] column;
    logic              last;
  } res_t;

  // truncated per-channel average of two ARGB pixels
  function automatic logic [PIX_W-1:0] blend_argb(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [8:0]       s;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      s = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
      r[8*c +: 8] = s[8:1];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/spc_cfg.sv =====
// ----------------------------------------------------------------------------
// spc_cfg
// Configuration registers and clamped frame size.
// ----------------------------------------------------------------------------
module spc_cfg #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned CW         = $clog2(MAX_WIDTH) + 1,
  parameter int unsigned CH         = $clog2(MAX_HEIGHT) + 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output spc_pkg::cfg_t                    cfg_o,
  output logic [CW-1:0]                    width_o,
  output logic [CH-1:0]                    height_o
);

  spc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= spc_pkg::MODE_LEFT;
      cfg_q.swap       <= 1'b0;
      cfg_q.width_raw  <= spc_pkg::WIDTH_RST;
      cfg_q.height_raw <= spc_pkg::HEIGHT_RST;
      cfg_q.left_on    <= 1'b1;
      cfg_q.right_on   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spc_pkg::REG_MODE:   cfg_q.mode       <= spc_pkg::mode_e'(cfg_wdata_i[2:0]);
        spc_pkg::REG_SWAP:   cfg_q.swap       <= cfg_wdata_i[0];
        spc_pkg::REG_WIDTH:  cfg_q.width_raw  <= cfg_wdata_i;
        spc_pkg::REG_HEIGHT: cfg_q.height_raw <= cfg_wdata_i;
        spc_pkg::REG_LEFT:   cfg_q.left_on    <= cfg_wdata_i[0];
        spc_pkg::REG_RIGHT:  cfg_q.right_on   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates at the maximum
  always_comb begin
    if (cfg_q.width_raw == '0) begin
      width_o = CW'(1);
    end else if ({1'b0, cfg_q.width_raw} > 14'(MAX_WIDTH)) begin
      width_o = CW'(MAX_WIDTH);
    end else begin
      width_o = CW'(cfg_q.width_raw);
    end
    if (cfg_q.height_raw == '0) begin
      height_o = CH'(1);
    end else if ({1'b0, cfg_q.height_raw} > 14'(MAX_HEIGHT)) begin
      height_o = CH'(MAX_HEIGHT);
    end else begin
      height_o = CH'(cfg_q.height_raw);
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/spc_raster.sv =====
// ----------------------------------------------------------------------------
// spc_raster
// Column and row counters; position and end-of-frame flag of the next item.
// ----------------------------------------------------------------------------
module spc_raster #(
  parameter int unsigned XW = 12,
  parameter int unsigned YW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [XW:0]     width_i,
  input  logic [YW:0]     height_i,
  output logic [XW-1:0]   x_o,
  output logic [YW-1:0]   y_o,
  output logic            frame_end_o
);

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [XW:0]   x_inc;
  logic [YW:0]   y_inc;
  logic          row_end;

  // at-or-past compares also catch counters left over from a larger size
  assign x_inc       = {1'b0, x_q} + (XW+1)'(1);
  assign y_inc       = {1'b0, y_q} + (YW+1)'(1);
  assign row_end     = x_inc >= width_i;
  assign frame_end_o = row_end && (y_inc >= height_i);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (step_i) begin
      if (row_end) begin
        x_d = '0;
        y_d = frame_end_o ? '0 : y_inc[YW-1:0];
      end else begin
        x_d = x_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ===== hw/rtl/spc_compose.sv =====
// ----------------------------------------------------------------------------
// spc_compose
// Pixel selection and mixing for one pixel pair; phase picks the second
// result of side by side.
// ----------------------------------------------------------------------------
module spc_compose #(
  parameter int unsigned XW = 12,
  parameter int unsigned YW = 12
) (
  input  spc_pkg::cfg_t                cfg_i,
  input  logic [XW:0]                  width_i,
  input  logic [spc_pkg::PIX_W-1:0]    left_i,
  input  logic [spc_pkg::PIX_W-1:0]    right_i,
  input  logic [XW-1:0]                x_i,
  input  logic [YW-1:0]                y_i,
  input  logic                         phase_i,
  output spc_pkg::res_t                res_o,
  output logic [1:0]                   count_o
);

  logic [spc_pkg::PIX_W-1:0] lp, rp, pix;
  logic                      lhas, rhas;
  logic [XW+1:0]             col_sum;

  assign lp   = cfg_i.swap ? right_i : left_i;
  assign rp   = cfg_i.swap ? left_i : right_i;
  assign lhas = cfg_i.swap ? cfg_i.right_on : cfg_i.left_on;
  assign rhas = cfg_i.swap ? cfg_i.left_on : cfg_i.right_on;

  assign col_sum = {1'b0, width_i} + (XW+2)'(x_i);

  always_comb begin
    case (cfg_i.mode)
      spc_pkg::MODE_RIGHT:    pix = rp;
      spc_pkg::MODE_SBS:      pix = phase_i ? rp : lp;
      spc_pkg::MODE_ANAGLYPH: pix = {spc_pkg::ALPHA_OPAQUE, lp[23:16], rp[15:0]};
      spc_pkg::MODE_ROW:      pix = y_i[0] ? rp : lp;
      spc_pkg::MODE_COLUMN:   pix = x_i[0] ? rp : lp;
      spc_pkg::MODE_BLEND:    pix = spc_pkg::blend_argb(lp, rp);
      default:                pix = lp;
    endcase

    res_o.column = spc_pkg::OCOL_W'(x_i);
    res_o.last   = 1'b1;
    count_o      = 2'd1;
    if (lhas && rhas) begin
      res_o.pixel = pix;
      if (cfg_i.mode == spc_pkg::MODE_SBS) begin
        count_o = 2'd2;
        res_o.last = phase_i;
        if (phase_i) begin
          res_o.column = spc_pkg::OCOL_W'(col_sum);
        end
      end
    end else if (lhas) begin
      res_o.pixel = lp;
    end else begin
      res_o.pixel = rp;
      if (!rhas) begin
        count_o = 2'd0;
      end
    end
  end

endmodule

// ===== hw/rtl/stereo_pixel_composer.sv =====
// Pipeline: an accepted item is held in the input register; its result is then
//   loaded into the output register once that register is free.
// Throughput: one item per cycle while the output is not stalled; side by side
//   gives two results per item, and the single output register carries one a cycle.
// Reset: asynchronous, active low; counters clear, registers take their
//   reset values, both stages empty.
// ----------------------------------------------------------------------------
// stereo_pixel_composer
// Composes left/right camera pixel pairs into stereo output pixels.
// ----------------------------------------------------------------------------
`include "stereo_pixel_composer_macros.svh"

module stereo_pixel_composer #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [spc_pkg::PIX_W-1:0]        left_pixel_i,
  input  logic [spc_pkg::PIX_W-1:0]        right_pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [spc_pkg::PIX_W-1:0]        out_pixel_o,
  output logic [spc_pkg::OCOL_W-1:0]       out_column_o,
  output logic [spc_pkg::OROW_W-1:0]       out_row_o,
  output logic                             frame_done_o,
  output logic                             last_of_item_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  spc_pkg::cfg_t cfg;
  logic [XW:0]   width;
  logic [YW:0]   height;
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic          cur_done;
  logic          in_fire;

  // input stage
  logic                      a_valid_q, a_phase_q, a_done_q;
  logic [spc_pkg::PIX_W-1:0] a_left_q, a_right_q;
  logic [XW-1:0]             a_x_q;
  logic [YW-1:0]             a_y_q;

  // output stage
  logic                       b_valid_q;
  logic [spc_pkg::PIX_W-1:0]  b_pixel_q;
  logic [spc_pkg::OCOL_W-1:0] b_column_q;
  logic [spc_pkg::OROW_W-1:0] b_row_q;
  logic                       b_done_q, b_last_q;

  spc_pkg::res_t res;
  logic [1:0]    res_count;
  logic          slot_free, b_load, a_retire;

  spc_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (XW + 1),
    .CH         (YW + 1)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .width_o     (width),
    .height_o    (height)
  );

  spc_raster #(
    .XW (XW),
    .YW (YW)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .width_i     (width),
    .height_i    (height),
    .x_o         (cur_x),
    .y_o         (cur_y),
    .frame_end_o (cur_done)
  );

  spc_compose #(
    .XW (XW),
    .YW (YW)
  ) u_compose (
    .cfg_i   (cfg),
    .width_i (width),
    .left_i  (a_left_q),
    .right_i (a_right_q),
    .x_i     (a_x_q),
    .y_i     (a_y_q),
    .phase_i (a_phase_q),
    .res_o   (res),
    .count_o (res_count)
  );

  assign slot_free = !b_valid_q || out_ready_i;
  assign b_load    = a_valid_q && (res_count != 2'd0) && slot_free;
  // an item with no source leaves without using the output slot
  assign a_retire  = a_valid_q && ((res_count == 2'd0) || (slot_free && res.last));
  assign in_ready_o = !a_valid_q || a_retire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_phase_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_retire) begin
        a_valid_q <= 1'b0;
      end
      if (a_retire) begin
        a_phase_q <= 1'b0;
      end else if (b_load) begin
        a_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_left_q  <= left_pixel_i;
      a_right_q <= right_pixel_i;
      a_x_q     <= cur_x;
      a_y_q     <= cur_y;
      a_done_q  <= cur_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (slot_free) begin
      b_valid_q <= b_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_pixel_q  <= res.pixel;
      b_column_q <= res.column;
      b_row_q    <= spc_pkg::OROW_W'(a_y_q);
      b_done_q   <= a_done_q;
      b_last_q   <= res.last;
    end
  end

  assign out_valid_o    = b_valid_q;
  assign out_pixel_o    = b_pixel_q;
  assign out_column_o   = b_column_q;
  assign out_row_o      = b_row_q;
  assign frame_done_o   = b_done_q;
  assign last_of_item_o = b_last_q;

  `SPC_ASSERT_NOW(a_phase_has_item, a_phase_q, a_valid_q,
    "second-result phase set with empty input stage")
  `SPC_ASSERT_NEXT(a_sbs_second_follows, out_valid_o && out_ready_i && !last_of_item_o,
    out_valid_o && last_of_item_o,
    "second side-by-side result did not follow its first")
  `SPC_ASSERT_NOW(a_empty_takes_input, !a_valid_q, in_ready_o,
    "input stalled while input stage empty")

endmodule

// ===== dv/stereo_compose_checker.sv =====
// ----------------------------------------------------------------------------
// stereo_compose_checker
// Watches the config port and both item channels of the stereo pixel
// composer, predicts the composed pixels of every accepted pair and compares
// each returned item against the oldest prediction.
// ----------------------------------------------------------------------------
module stereo_compose_checker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [spc_pkg::PIX_W-1:0]        left_pixel_i,
  input  logic [spc_pkg::PIX_W-1:0]        right_pixel_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [spc_pkg::PIX_W-1:0]        out_pixel_i,
  input  logic [spc_pkg::OCOL_W-1:0]       out_column_i,
  input  logic [spc_pkg::OROW_W-1:0]       out_row_i,
  input  logic                             frame_done_i,
  input  logic                             last_of_item_i,
  output int unsigned                      mismatches_o,
  output int unsigned                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [spc_pkg::PIX_W-1:0]  pixel;
    logic [spc_pkg::OCOL_W-1:0] column;
    logic [spc_pkg::OROW_W-1:0] row;
    logic                       frame_end;
    logic                       last;
  } composed_t;

  composed_t                  composed_q[$];
  composed_t                  oldest;
  spc_pkg::mode_e             mode_q;
  logic                       swap_q;
  logic [spc_pkg::SIZE_W-1:0] width_q;
  logic [spc_pkg::SIZE_W-1:0] height_q;
  logic                       left_on_q;
  logic                       right_on_q;
  int unsigned                col_q;
  int unsigned                row_q;
  int unsigned                fail_count;
  int unsigned                results_checked;

  task automatic queue_composed(input logic [spc_pkg::PIX_W-1:0] pix, input int unsigned x,
                                input int unsigned y, input logic done, input logic last);
    composed_t r;
    r.pixel     = pix;
    r.column    = x[spc_pkg::OCOL_W-1:0];
    r.row       = y[spc_pkg::OROW_W-1:0];
    r.frame_end = done;
    r.last      = last;
    composed_q.push_back(r);
  endtask

  // one input pair: queue its composed pixels and step the raster position
  task automatic compose_pair(input logic [spc_pkg::PIX_W-1:0] lpx,
                              input logic [spc_pkg::PIX_W-1:0] rpx);
    int unsigned               w;
    int unsigned               h;
    int unsigned               x;
    int unsigned               y;
    logic [spc_pkg::PIX_W-1:0] a;
    logic [spc_pkg::PIX_W-1:0] b;
    logic [spc_pkg::PIX_W-1:0] pix;
    logic                      has_a;
    logic                      has_b;
    logic                      row_end;
    logic                      frame_end;
    logic [8:0]                chan_sum;
    w = (width_q == '0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q == '0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
    x = col_q;
    y = row_q;
    row_end   = (x + 1 >= w);
    frame_end = row_end && (y + 1 >= h);
    if (swap_q) begin
      a = rpx; has_a = right_on_q;
      b = lpx; has_b = left_on_q;
    end else begin
      a = lpx; has_a = left_on_q;
      b = rpx; has_b = right_on_q;
    end
    pix = a;
    if (has_a && has_b) begin
      case (mode_q)
        spc_pkg::MODE_RIGHT:    pix = b;
        spc_pkg::MODE_ANAGLYPH: pix = {spc_pkg::ALPHA_OPAQUE, a[23:16], b[15:0]};
        spc_pkg::MODE_ROW:      pix = y[0] ? b : a;
        spc_pkg::MODE_COLUMN:   pix = x[0] ? b : a;
        spc_pkg::MODE_BLEND: begin
          for (int c = 0; c < 4; c++) begin
            chan_sum = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
            pix[8*c +: 8] = chan_sum[8:1];
          end
        end
        default:                pix = a;
      endcase
      if (mode_q == spc_pkg::MODE_SBS) begin
        queue_composed(a, x, y, frame_end, 1'b0);
        queue_composed(b, w + x, y, frame_end, 1'b1);
      end else begin
        queue_composed(pix, x, y, frame_end, 1'b1);
      end
    end else if (has_a) begin
      queue_composed(a, x, y, frame_end, 1'b1);
    end else if (has_b) begin
      queue_composed(b, x, y, frame_end, 1'b1);
    end
    // position advances even when nothing comes out
    if (row_end) begin
      col_q = 0;
      row_q = frame_end ? 0 : y + 1;
    end else begin
      col_q = x + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      composed_q.delete();
      mode_q          = spc_pkg::MODE_LEFT;
      swap_q          = 1'b0;
      width_q         = spc_pkg::WIDTH_RST;
      height_q        = spc_pkg::HEIGHT_RST;
      left_on_q       = 1'b1;
      right_on_q      = 1'b1;
      col_q           = 0;
      row_q           = 0;
      fail_count      = 0;
      results_checked = 0;
      mismatches_o   <= 0;
      pending_o      <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_checked++;
        if (composed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: item %0d unexpected: pixel %h col %0d row %0d done %b last %b",
                     $time, results_checked, out_pixel_i, out_column_i, out_row_i,
                     frame_done_i, last_of_item_i);
        end else begin
          oldest = composed_q.pop_front();
          if (out_pixel_i !== oldest.pixel || out_column_i !== oldest.column ||
              out_row_i !== oldest.row || frame_done_i !== oldest.frame_end ||
              last_of_item_i !== oldest.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: item %0d mismatch", $time, results_checked);
              $display("  expected pixel %h col %0d row %0d done %b last %b",
                       oldest.pixel, oldest.column, oldest.row, oldest.frame_end,
                       oldest.last);
              $display("  actual   pixel %h col %0d row %0d done %b last %b",
                       out_pixel_i, out_column_i, out_row_i, frame_done_i,
                       last_of_item_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) compose_pair(left_pixel_i, right_pixel_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          spc_pkg::REG_MODE:   mode_q     = spc_pkg::mode_e'(cfg_wdata_i[2:0]);
          spc_pkg::REG_SWAP:   swap_q     = cfg_wdata_i[0];
          spc_pkg::REG_WIDTH:  width_q    = cfg_wdata_i[spc_pkg::SIZE_W-1:0];
          spc_pkg::REG_HEIGHT: height_q   = cfg_wdata_i[spc_pkg::SIZE_W-1:0];
          spc_pkg::REG_LEFT:   left_on_q  = cfg_wdata_i[0];
          spc_pkg::REG_RIGHT:  right_on_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o    <= composed_q.size();
      mismatches_o <= fail_count;
    end
  end

endmodule

// ===== dv/tb_stereo_pixel_composer.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_pixel_composer
// Drives pixel pairs and register settings into the stereo pixel composer,
// with random gaps and stalls on both channels; the checker beside the block
// predicts and compares every composed item.
// ----------------------------------------------------------------------------
module tb_stereo_pixel_composer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS_TOTAL    = 550;
  localparam int unsigned CALM_TAIL      = 80;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                           in_valid_i    = 1'b0;
  logic [spc_pkg::PIX_W-1:0]      left_pixel_i  = '0;
  logic [spc_pkg::PIX_W-1:0]      right_pixel_i = '0;
  logic                           out_ready_i   = 1'b0;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [spc_pkg::PIX_W-1:0]      out_pixel_o;
  logic [spc_pkg::OCOL_W-1:0]     out_column_o;
  logic [spc_pkg::OROW_W-1:0]     out_row_o;
  logic                           frame_done_o;
  logic                           last_of_item_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned settings     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  bit          stall_req    = 1'b0;
  bit          stall_taken  = 1'b0;

  logic [spc_pkg::PIX_W-1:0] dir_left  [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                               32'h80FF_7F01, 32'h1234_5678};
  logic [spc_pkg::PIX_W-1:0] dir_right [4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                               32'h7F01_80FE, 32'h9ABC_DEF0};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stereo_pixel_composer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_pixel_i   (left_pixel_i),
    .right_pixel_i  (right_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_o    (out_pixel_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .frame_done_o   (frame_done_o),
    .last_of_item_o (last_of_item_o)
  );

  stereo_compose_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .left_pixel_i   (left_pixel_i),
    .right_pixel_i  (right_pixel_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_i    (out_pixel_o),
    .out_column_i   (out_column_o),
    .out_row_i      (out_row_o),
    .frame_done_i   (frame_done_o),
    .last_of_item_i (last_of_item_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // output side: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) results_seen <= results_seen + 1;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_stereo_pixel_composer: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic cfg_write(input logic [spc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_all(input spc_pkg::mode_e m, input logic sw,
                         input logic [spc_pkg::SIZE_W-1:0] w,
                         input logic [spc_pkg::SIZE_W-1:0] h,
                         input logic lon, input logic ron);
    cfg_write(spc_pkg::REG_MODE, spc_pkg::CFG_DATA_W'(m));
    cfg_write(spc_pkg::REG_SWAP, spc_pkg::CFG_DATA_W'(sw));
    cfg_write(spc_pkg::REG_WIDTH, w);
    cfg_write(spc_pkg::REG_HEIGHT, h);
    cfg_write(spc_pkg::REG_LEFT, spc_pkg::CFG_DATA_W'(lon));
    cfg_write(spc_pkg::REG_RIGHT, spc_pkg::CFG_DATA_W'(ron));
    settings++;
  endtask

  task automatic send_pair(input logic [spc_pkg::PIX_W-1:0] lpx,
                           input logic [spc_pkg::PIX_W-1:0] rpx);
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    left_pixel_i  <= lpx;
    right_pixel_i <= rpx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // drop valid, wait for every predicted item, then let items with no
  // output clear the pipeline
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [spc_pkg::PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 9) == 0) return dir_left[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  initial begin
    spc_pkg::mode_e             m;
    logic                       sw;
    logic                       lon;
    logic                       ron;
    logic [spc_pkg::SIZE_W-1:0] w;
    logic [spc_pkg::SIZE_W-1:0] h;
    int unsigned                n;
    int unsigned                pick;
    int unsigned                phase;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    gap_pct   = 10;
    stall_pct = 10;

    // reset settings: left only, 640 x 480
    send_pair(dir_left[0], dir_right[0]);
    send_pair(dir_left[1], dir_right[1]);
    settle();

    // every mode on a 2 x 2 frame; the first setting shrinks the width to the column count
    m = m.first();
    do begin
      set_all(m, 1'b0, 13'd2, 13'd2, 1'b1, 1'b1);
      send_pair(dir_left[2], dir_right[2]);
      send_pair(dir_left[3], dir_right[3]);
      settle();
      m = m.next();
    end while (m != m.first());

    set_all(spc_pkg::MODE_ANAGLYPH, 1'b1, 13'd3, 13'd1, 1'b1, 1'b1);
    send_pair(dir_left[2], dir_right[3]);
    send_pair(dir_left[3], dir_right[2]);
    settle();

    // one source only, then none
    set_all(spc_pkg::MODE_SBS, 1'b0, 13'd3, 13'd2, 1'b1, 1'b0);
    send_pair(dir_left[2], dir_right[2]);
    settle();
    set_all(spc_pkg::MODE_BLEND, 1'b1, 13'd3, 13'd2, 1'b0, 1'b1);
    send_pair(dir_left[3], dir_right[3]);
    settle();
    set_all(spc_pkg::MODE_SBS, 1'b0, 13'd3, 13'd2, 1'b0, 1'b0);
    send_pair(dir_left[0], dir_right[1]);
    send_pair(dir_left[1], dir_right[0]);
    settle();

    // zero sizes count as one, oversize clamps to the maximum
    set_all(spc_pkg::MODE_SBS, 1'b0, 13'd0, 13'd0, 1'b1, 1'b1);
    send_pair(dir_left[1], dir_right[2]);
    send_pair(dir_left[2], dir_right[1]);
    settle();
    set_all(spc_pkg::MODE_SBS, 1'b0, 13'h1FFF, 13'h1FFF, 1'b1, 1'b1);
    send_pair(dir_left[3], dir_right[0]);
    send_pair(dir_left[0], dir_right[3]);
    settle();

    phase = 0;
    while (items_sent < ITEMS_TOTAL) begin
      m  = spc_pkg::mode_e'($urandom_range(0, 7));
      sw = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 70)      w = spc_pkg::SIZE_W'($urandom_range(1, 6));
      else if (pick < 80) w = spc_pkg::SIZE_W'($urandom_range(7, 40));
      else if (pick < 85) w = '0;
      else if (pick < 90) w = 13'd4096;
      else if (pick < 95) w = spc_pkg::SIZE_W'($urandom_range(4097, 8191));
      else                w = spc_pkg::SIZE_W'($urandom_range(0, 8191));
      pick = $urandom_range(0, 99);
      if (pick < 75)      h = spc_pkg::SIZE_W'($urandom_range(1, 4));
      else if (pick < 85) h = spc_pkg::SIZE_W'($urandom_range(5, 20));
      else if (pick < 90) h = '0;
      else                h = spc_pkg::SIZE_W'($urandom_range(4096, 8191));
      if ($urandom_range(0, 99) < 70) begin
        lon = 1'b1;
        ron = 1'b1;
      end else begin
        lon = 1'($urandom_range(0, 1));
        ron = 1'($urandom_range(0, 1));
      end
      n = $urandom_range(8, 40);
      if (phase == 3) begin
        // long output hold-off while the sender keeps offering
        m   = spc_pkg::MODE_SBS;
        lon = 1'b1;
        ron = 1'b1;
        n   = 40;
      end
      if (items_sent + CALM_TAIL >= ITEMS_TOTAL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick      = $urandom_range(0, 2);
        gap_pct   = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
        pick      = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
      end
      set_all(m, sw, w, h, lon, ron);
      if (phase == 3) stall_req = 1'b1;
      repeat (n) send_pair(rand_pixel(), rand_pixel());
      settle();
      phase++;
    end

    $display("sent %0d pixel pairs over %0d register settings, %0d composed items back",
             items_sent, settings, results_seen);
    $display("all modes, swapped roles, one and no source, size clamps, long output hold");
    if (mismatches == 0) begin
      $display("tb_stereo_pixel_composer: done, clean");
    end else begin
      $display("tb_stereo_pixel_composer: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_cfg.sv
hw/rtl/spc_raster.sv
hw/rtl/spc_compose.sv
hw/rtl/stereo_pixel_composer.sv
dv/stereo_compose_checker.sv
dv/tb_stereo_pixel_composer.sv
